// File: hw/rtl/variance_clamp_pixel_macros.svh
// assertion macros for the variance clamp pixel block
// used by vcp_div and variance_clamp_pixel; expects clk and rst_n in scope
`ifndef VARIANCE_CLAMP_PIXEL_MACROS_SVH
`define VARIANCE_CLAMP_PIXEL_MACROS_SVH
`ifndef NO_ASSERTIONS
`define VCP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vcp assertion failed");
`define VCP_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("vcp assertion failed");
`else
`define VCP_ASSERT_IMP(lbl, ante, cons)
`define VCP_ASSERT_NEVER(lbl, cond)
`endif
`endif

// File: hw/rtl/vcp_pkg.sv
// shared types, constants and fixed point helpers of the variance clamp pixel block
// no dependencies
package vcp_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DW        = 32;
  localparam int DQ_W      = 33 + FRAC_BITS;
  localparam int REM_W     = DW + 1;
  localparam int LAT       = 2 * DQ_W + 7;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHTED = 2'd1;

  localparam logic signed [DW-1:0] S32_MAX = 32'sh7fffffff;
  localparam logic signed [DW-1:0] S32_MIN = 32'sh80000000;
  localparam logic signed [63:0]   P_MAX   = 64'sd2147483647;
  localparam logic signed [63:0]   P_MIN   = -64'sd2147483648;

  typedef enum logic [1:0] {
    ACT_NONE = 2'd0,
    ACT_HIGH = 2'd1,
    ACT_LOW  = 2'd2,
    ACT_SKIP = 2'd3
  } action_t;

  typedef struct packed {
    logic signed [DW-1:0] er;
    logic signed [DW-1:0] eg;
    logic signed [DW-1:0] eb;
    logic signed [DW-1:0] sr;
    logic signed [DW-1:0] sg;
    logic signed [DW-1:0] sb;
    logic signed [DW-1:0] sw;
    logic                 ew_pos;
    logic                 skip;
    logic                 neg;
    action_t              act;
  } side_t;

  function automatic logic signed [DW-1:0] sat_prod(input logic signed [63:0] p);
    logic signed [63:0] sh;
    sh = p >>> FRAC_BITS;
    if (sh > P_MAX) return S32_MAX;
    else if (sh < P_MIN) return S32_MIN;
    else return sh[DW-1:0];
  endfunction

  function automatic logic signed [DW-1:0] sat_quot(input logic [DQ_W-1:0] q);
    if (|q[DQ_W-1:DW-1]) return S32_MAX;
    else return $signed(q[DW-1:0]);
  endfunction

endpackage

// File: hw/rtl/variance_clamp_pixel.sv
// variance clamp of one pixel sample against an expected pixel, top level
// depends on vcp_pkg, vcp_div, vcp_range, vcp_scale and the macros header
//
// usage:
//   input beat: drive the expected pixel (in_exp_*) and the sample (in_smp_*)
//   and raise in_start; the beat is taken at a rising edge with busy low.
//   busy is low whenever reset is released, so a beat may come every cycle.
//   result beat: out_valid is high for one cycle with out_red, out_green,
//   out_blue, out_weight and out_action; the receiver cannot stall it.
//   the path is two levels of pipelined restoring dividers of one
//   quotient bit per stage (weight reciprocals, then the scale factor)
//   plus seven arithmetic stages.
//   throughput is one beat per cycle, in order.
//   cfg port: cfg_index 0 is the clamp limit (cfg_data[30:0]), 1 is the
//   weighted sample flag (cfg_data[0]); cfg_ready is always high. write it
//   only while no beat is in flight.
//   reset: synchronous active low; clears all valid bits, limit 0, weighted 1.
`include "variance_clamp_pixel_macros.svh"
module variance_clamp_pixel (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_start,
  output logic                          busy,
  input  logic signed [vcp_pkg::DW-1:0] in_exp_red,
  input  logic signed [vcp_pkg::DW-1:0] in_exp_green,
  input  logic signed [vcp_pkg::DW-1:0] in_exp_blue,
  input  logic signed [vcp_pkg::DW-1:0] in_exp_weight,
  input  logic signed [vcp_pkg::DW-1:0] in_smp_red,
  input  logic signed [vcp_pkg::DW-1:0] in_smp_green,
  input  logic signed [vcp_pkg::DW-1:0] in_smp_blue,
  input  logic signed [vcp_pkg::DW-1:0] in_smp_weight,
  output logic                          out_valid,
  output logic signed [vcp_pkg::DW-1:0] out_red,
  output logic signed [vcp_pkg::DW-1:0] out_green,
  output logic signed [vcp_pkg::DW-1:0] out_blue,
  output logic signed [vcp_pkg::DW-1:0] out_weight,
  output logic [1:0]                    out_action,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [vcp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [vcp_pkg::DW-1:0]        cfg_data
);
  import vcp_pkg::*;

  logic [30:0]     limit_r;
  logic            weighted_r;
  logic            in_acc;
  side_t           side_in, side_d, side_r4, side_q;
  logic [DQ_W-1:0] recip_num, quot_e, quot_s, quot_m;
  logic [DW-1:0]   div_e, div_s;
  logic            v_div, v_rng, v_q;
  logic [DQ_W-1:0] num_m;
  logic [DW-1:0]   den_m;

  assign busy      = ~rst_n;
  assign cfg_ready = 1'b1;
  assign in_acc    = in_start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r    <= '0;
      weighted_r <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_LIMIT:    limit_r    <= cfg_data[30:0];
        CFG_WEIGHTED: weighted_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    recip_num      = DQ_W'(1) << (2 * FRAC_BITS);
    div_e          = (in_exp_weight > 0) ? in_exp_weight : 32'd1;
    div_s          = (in_smp_weight > 0) ? in_smp_weight : 32'd1;
    side_in.er     = in_exp_red;
    side_in.eg     = in_exp_green;
    side_in.eb     = in_exp_blue;
    side_in.sr     = in_smp_red;
    side_in.sg     = in_smp_green;
    side_in.sb     = in_smp_blue;
    side_in.sw     = in_smp_weight;
    side_in.ew_pos = in_exp_weight > 0;
    side_in.skip   = weighted_r && (in_smp_weight <= 0);
    side_in.neg    = 1'b0;
    side_in.act    = ACT_NONE;
  end

  vcp_div u_recip_e (
    .clk(clk), .rst_n(rst_n), .in_valid(in_acc), .dividend(recip_num),
    .divisor(div_e), .side_i(side_in), .out_valid(v_div), .quotient(quot_e),
    .side_o(side_d)
  );

  vcp_div u_recip_s (
    .clk(clk), .rst_n(rst_n), .in_valid(in_acc), .dividend(recip_num),
    .divisor(div_s), .side_i(side_in), .out_valid(), .quotient(quot_s),
    .side_o()
  );

  vcp_range u_range (
    .clk(clk), .rst_n(rst_n), .limit(limit_r), .weighted(weighted_r),
    .in_valid(v_div), .quot_e(quot_e), .quot_s(quot_s), .side_i(side_d),
    .out_valid(v_rng), .dividend(num_m), .divisor(den_m), .side_o(side_r4)
  );

  vcp_div u_quot (
    .clk(clk), .rst_n(rst_n), .in_valid(v_rng), .dividend(num_m),
    .divisor(den_m), .side_i(side_r4), .out_valid(v_q), .quotient(quot_m),
    .side_o(side_q)
  );

  vcp_scale u_scale (
    .clk(clk), .rst_n(rst_n), .in_valid(v_q), .quotient(quot_m),
    .side_i(side_q), .out_valid(out_valid), .out_red(out_red),
    .out_green(out_green), .out_blue(out_blue), .out_weight(out_weight),
    .out_action(out_action)
  );

  `VCP_ASSERT_IMP(a_beat_arrives, $past(in_acc, LAT), out_valid)
  `VCP_ASSERT_IMP(a_no_phantom, out_valid, $past(in_acc, LAT))
  `VCP_ASSERT_IMP(a_skip_on_weight, out_valid && weighted_r && (out_weight <= 0),
                  out_action == ACT_SKIP)
  `VCP_ASSERT_NEVER(a_skip_plain, out_valid && (out_action == ACT_SKIP) && !weighted_r)

endmodule

// File: hw/rtl/vcp_div.sv
// pipelined unsigned restoring divider, one quotient bit per stage
// depends on vcp_pkg and variance_clamp_pixel_macros.svh
`include "variance_clamp_pixel_macros.svh"
module vcp_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic [vcp_pkg::DQ_W-1:0]    dividend,
  input  logic [vcp_pkg::DW-1:0]      divisor,
  input  vcp_pkg::side_t              side_i,
  output logic                        out_valid,
  output logic [vcp_pkg::DQ_W-1:0]    quotient,
  output vcp_pkg::side_t              side_o
);
  import vcp_pkg::*;

  logic             vld_r  [DQ_W];
  logic [REM_W-1:0] rem_r  [DQ_W];
  logic [DQ_W-1:0]  dq_r   [DQ_W];
  logic [DW-1:0]    d_r    [DQ_W];
  side_t            side_r [DQ_W];

  for (genvar k = 0; k < DQ_W; k++) begin : g_stage
    logic             v_in;
    logic [REM_W-1:0] rem_in;
    logic [DQ_W-1:0]  dq_in;
    logic [DW-1:0]    d_in;
    side_t            s_in;
    logic [REM_W-1:0] sh;
    logic [REM_W:0]   diff;
    logic [REM_W-1:0] rem_nxt;
    logic [DQ_W-1:0]  dq_nxt;

    if (k == 0) begin : g_first
      assign v_in   = in_valid;
      assign rem_in = '0;
      assign dq_in  = dividend;
      assign d_in   = divisor;
      assign s_in   = side_i;
    end else begin : g_next
      assign v_in   = vld_r[k-1];
      assign rem_in = rem_r[k-1];
      assign dq_in  = dq_r[k-1];
      assign d_in   = d_r[k-1];
      assign s_in   = side_r[k-1];
    end

    always_comb begin
      sh   = {rem_in[REM_W-2:0], dq_in[DQ_W-1]};
      diff = {1'b0, sh} - {2'b00, d_in};
      if (!diff[REM_W]) begin
        rem_nxt = diff[REM_W-1:0];
        dq_nxt  = {dq_in[DQ_W-2:0], 1'b1};
      end else begin
        rem_nxt = sh;
        dq_nxt  = {dq_in[DQ_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= v_in;
      end
      rem_r[k]  <= rem_nxt;
      dq_r[k]   <= dq_nxt;
      d_r[k]    <= d_in;
      side_r[k] <= s_in;
    end
  end

  assign out_valid = vld_r[DQ_W-1];
  assign quotient  = dq_r[DQ_W-1];
  assign side_o    = side_r[DQ_W-1];

  `VCP_ASSERT_IMP(a_rem_below_divisor, vld_r[DQ_W-1], rem_r[DQ_W-1] < {1'b0, d_r[DQ_W-1]})
  `VCP_ASSERT_NEVER(a_zero_divisor, in_valid && (divisor == '0))

endmodule

// File: hw/rtl/vcp_range.sv
// normalization, min/max, clamp band and decision stages
// depends on vcp_pkg
module vcp_range (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [30:0]              limit,
  input  logic                     weighted,
  input  logic                     in_valid,
  input  logic [vcp_pkg::DQ_W-1:0] quot_e,
  input  logic [vcp_pkg::DQ_W-1:0] quot_s,
  input  vcp_pkg::side_t           side_i,
  output logic                     out_valid,
  output logic [vcp_pkg::DQ_W-1:0] dividend,
  output logic [vcp_pkg::DW-1:0]   divisor,
  output vcp_pkg::side_t           side_o
);
  import vcp_pkg::*;

  logic                 v1_r, v2_r, v3_r, v4_r;
  side_t                s1_r, s2_r, s3_r, s4_r, s4_nxt;
  logic signed [63:0]   per_r, peg_r, peb_r, psr_r, psg_r, psb_r;
  logic signed [DW-1:0] ner_r, neg_r, neb_r, nsr_r, nsg_r, nsb_r;
  logic signed [DW-1:0] mn_r, mx_r, m_r;
  logic signed [DW-1:0] inv_e, inv_s;
  logic signed [DW-1:0] mn_nxt, mx_nxt, m_nxt, ms_nxt;
  logic signed [DW:0]   lo_w, hi_w;
  logic signed [DW-1:0] low, high, bound;
  logic [DW-1:0]        mag;
  action_t              act;
  logic [DQ_W-1:0]      dividend_r, dividend_nxt;
  logic [DW-1:0]        divisor_r, divisor_nxt;

  assign inv_e = sat_quot(quot_e);
  assign inv_s = sat_quot(quot_s);

  always_comb begin
    mn_nxt = (ner_r < neg_r) ? ner_r : neg_r;
    mn_nxt = (mn_nxt < neb_r) ? mn_nxt : neb_r;
    mx_nxt = (ner_r > neg_r) ? ner_r : neg_r;
    mx_nxt = (mx_nxt > neb_r) ? mx_nxt : neb_r;
    if (weighted) begin
      ms_nxt = (nsr_r > nsg_r) ? nsr_r : nsg_r;
      m_nxt  = (ms_nxt > nsb_r) ? ms_nxt : nsb_r;
    end else begin
      ms_nxt = (s2_r.sr > s2_r.sg) ? s2_r.sr : s2_r.sg;
      m_nxt  = (ms_nxt > s2_r.sb) ? ms_nxt : s2_r.sb;
    end
  end

  always_comb begin
    lo_w = {mn_r[DW-1], mn_r} - $signed({2'b00, limit});
    hi_w = {mx_r[DW-1], mx_r} + $signed({2'b00, limit});
    if (s3_r.ew_pos) begin
      low  = lo_w[DW] ? '0 : lo_w[DW-1:0];
      high = (hi_w > $signed({1'b0, S32_MAX})) ? S32_MAX : hi_w[DW-1:0];
    end else begin
      low  = '0;
      high = $signed({1'b0, limit});
    end
    act   = ACT_NONE;
    bound = '0;
    if (s3_r.skip) begin
      act = ACT_SKIP;
    end else if (m_r > 0 && m_r > high) begin
      act   = ACT_HIGH;
      bound = high;
    end else if (m_r > 0 && m_r < low) begin
      act   = ACT_LOW;
      bound = low;
    end
    mag          = bound[DW-1] ? 32'(-bound) : 32'(bound);
    dividend_nxt = {1'b0, mag, {FRAC_BITS{1'b0}}};
    divisor_nxt  = (act == ACT_HIGH || act == ACT_LOW) ? m_r : 32'd1;
    s4_nxt       = s3_r;
    s4_nxt.act   = act;
    s4_nxt.neg   = bound[DW-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
    per_r <= side_i.er * inv_e;
    peg_r <= side_i.eg * inv_e;
    peb_r <= side_i.eb * inv_e;
    psr_r <= side_i.sr * inv_s;
    psg_r <= side_i.sg * inv_s;
    psb_r <= side_i.sb * inv_s;
    s1_r  <= side_i;
    ner_r <= sat_prod(per_r);
    neg_r <= sat_prod(peg_r);
    neb_r <= sat_prod(peb_r);
    nsr_r <= sat_prod(psr_r);
    nsg_r <= sat_prod(psg_r);
    nsb_r <= sat_prod(psb_r);
    s2_r  <= s1_r;
    mn_r  <= mn_nxt;
    mx_r  <= mx_nxt;
    m_r   <= m_nxt;
    s3_r  <= s2_r;
    dividend_r <= dividend_nxt;
    divisor_r  <= divisor_nxt;
    s4_r       <= s4_nxt;
  end

  assign out_valid = v4_r;
  assign dividend  = dividend_r;
  assign divisor   = divisor_r;
  assign side_o    = s4_r;

endmodule

// File: hw/rtl/vcp_scale.sv
// signed scale factor and channel scaling stages
// depends on vcp_pkg
module vcp_scale (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic [vcp_pkg::DQ_W-1:0]    quotient,
  input  vcp_pkg::side_t              side_i,
  output logic                        out_valid,
  output logic signed [vcp_pkg::DW-1:0] out_red,
  output logic signed [vcp_pkg::DW-1:0] out_green,
  output logic signed [vcp_pkg::DW-1:0] out_blue,
  output logic signed [vcp_pkg::DW-1:0] out_weight,
  output logic [1:0]                  out_action
);
  import vcp_pkg::*;

  logic                 v1_r, v2_r, v3_r;
  side_t                s1_r, s2_r;
  logic signed [DW-1:0] scale_r, scale_nxt;
  logic signed [63:0]   pr_r, pg_r, pb_r;
  logic signed [DW-1:0] red_r, green_r, blue_r, weight_r;
  action_t              act_r;
  logic                 over;

  always_comb begin
    over = (|quotient[DQ_W-1:DW]) || (quotient[DW-1] && (|quotient[DW-2:0]));
    if (!side_i.neg) begin
      scale_nxt = sat_quot(quotient);
    end else if (over) begin
      scale_nxt = S32_MIN;
    end else begin
      scale_nxt = -$signed(quotient[DW-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
    scale_r <= scale_nxt;
    s1_r    <= side_i;
    pr_r    <= s1_r.sr * scale_r;
    pg_r    <= s1_r.sg * scale_r;
    pb_r    <= s1_r.sb * scale_r;
    s2_r    <= s1_r;
    if (s2_r.act == ACT_HIGH || s2_r.act == ACT_LOW) begin
      red_r   <= sat_prod(pr_r);
      green_r <= sat_prod(pg_r);
      blue_r  <= sat_prod(pb_r);
    end else begin
      red_r   <= s2_r.sr;
      green_r <= s2_r.sg;
      blue_r  <= s2_r.sb;
    end
    weight_r <= s2_r.sw;
    act_r    <= s2_r.act;
  end

  assign out_valid  = v3_r;
  assign out_red    = red_r;
  assign out_green  = green_r;
  assign out_blue   = blue_r;
  assign out_weight = weight_r;
  assign out_action = act_r;

endmodule
